/* design/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, constants and helpers for the callsign hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int HASH_W        = 22;
    localparam int HEAD_W        = 64;
    localparam int TAIL_W        = 24;
    localparam int AGE_W         = 8;
    localparam int OCC_W         = 9;
    localparam int HOME_W        = 10;
    localparam int HOME_MULT     = 23;
    localparam int PROD_W        = 15;  // 1023 * 23 fits in 15 bits
    localparam int STEP_BITS     = 5;   // remainder bits retired per cycle
    localparam int HOME_STEPS    = PROD_W / STEP_BITS;
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd10;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SEL_10 = 2'd0,
        SEL_12 = 2'd1,
        SEL_22 = 2'd2,
        SEL_22B = 2'd3
    } sel_t;

    typedef struct packed {
        logic              used;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
        logic [HASH_W-1:0] hash;
        logic [AGE_W-1:0]  age;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Name ends at its first zero byte; later bytes forced to zero.
    function automatic logic [HEAD_W+TAIL_W-1:0] canon_name(
        input logic [HEAD_W+TAIL_W-1:0] name);
        logic [HEAD_W+TAIL_W-1:0] res;
        logic ended;
        res   = name;
        ended = 1'b0;
        for (int i = 10; i >= 0; i--)
        begin
            if (ended)
                res[i*8 +: 8] = 8'd0;
            else if (name[i*8 +: 8] == 8'd0)
                ended = 1'b1;
        end
        return res;
    endfunction

endpackage

/* design/cht_ram.sv */
// ----------------------------------------------------------------------------
// cht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/callsign_hash_table_aging.sv */
// ----------------------------------------------------------------------------
// callsign_hash_table_aging
// Open-addressed callsign table with linear probing and age sweep.
// ----------------------------------------------------------------------------
// Sequence: an add or lookup computes the home slot in ST_HOME, issues the
//   first read in ST_READ, checks one probed slot per cycle in ST_EVAL and
//   returns the result from ST_RESP; a sweep walks every slot in ST_EVAL.
// Items: one at a time, as s_tready is high only in ST_IDLE.
// Reset: asynchronous; afterwards a clearing pass over every slot zeroes
//   the slot memory, during which no item is taken (config is still taken).
module callsign_hash_table_aging
    import cht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    // config: max_age
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // hash_value[21:0], name_head[85:22], name_tail[109:86]
    input  logic [3:0]   s_tuser,   // cmd[1:0], hash_width_sel[3:2]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // found_head[63:0], found_tail[87:64], occupied_count[96:88]
    output logic [1:0]   m_tuser    // found[0], status[1]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [RW-1:0] DEPTH_R  = RW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HOME, ST_READ, ST_EVAL, ST_RESP
    } state_t;

    state_t               state_reg;
    logic [1:0]           cmd_reg;
    logic [1:0]           sel_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [HEAD_W-1:0]    head_reg;
    logic [TAIL_W-1:0]    tail_reg;
    logic [AGE_W-1:0]     max_age_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [RW-1:0]        rem_reg;
    logic [1:0]           step_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        n_reg;
    logic [CW-1:0]        count_reg;
    logic                 res_found_reg;
    logic                 res_status_reg;
    logic [HEAD_W-1:0]    res_head_reg;
    logic [TAIL_W-1:0]    res_tail_reg;
    logic                 m_tvalid_reg;
    logic [103:0]         m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    logic [HEAD_W+TAIL_W-1:0] name_canon;
    logic [HOME_W-1:0]    h10;
    logic [RW-1:0]        rem_next;
    logic [AW-1:0]        idx_inc;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [AW-1:0]        waddr;
    slot_t                wslot;
    slot_t                rslot;
    logic [SLOT_W-1:0]    rdata;
    logic [HASH_W-1:0]    cmp_hash;
    logic                 add_match;
    logic                 find_match;
    logic                 too_old;
    logic                 in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign name_canon = canon_name({s_tdata[85:22], s_tdata[109:86]});

    // Home slot source bits: the hash's top ten bits at the lookup width.
    always_comb
    begin
        h10 = s_tdata[21:12];
        if (s_tuser[1:0] == CMD_FIND)
        begin
            case (s_tuser[3:2])
                SEL_10:  h10 = s_tdata[9:0];
                SEL_12:  h10 = s_tdata[11:2];
                default: h10 = s_tdata[21:12];
            endcase
        end
    end

    // Restoring remainder by TABLE_DEPTH, STEP_BITS bits per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        for (int b = 0; b < STEP_BITS; b++)
        begin
            rem_next = {rem_next[RW-2:0], prod_reg[PROD_W-1-b]};
            if (rem_next >= DEPTH_R)
                rem_next = rem_next - DEPTH_R;
        end
    end

    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + AW'(1);
    assign raddr   = (state_reg == ST_EVAL) ? idx_inc : idx_reg;
    assign rslot   = slot_t'(rdata);

    always_comb
    begin
        case (sel_reg)
            SEL_10:  cmp_hash = rslot.hash >> 12;
            SEL_12:  cmp_hash = rslot.hash >> 10;
            default: cmp_hash = rslot.hash;
        endcase
    end

    assign add_match  = rslot.hash == hash_reg && rslot.head == head_reg &&
                        rslot.tail == tail_reg;
    assign find_match = cmp_hash == hash_reg;
    assign too_old    = rslot.age > max_age_reg;

    // Slot write: clearing pass, insert or refresh, and sweep update.
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wslot = '0;
        if (state_reg == ST_CLEAR)
            we = 1'b1;
        else if (state_reg == ST_EVAL)
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (!rslot.used || add_match)
                    begin
                        we    = 1'b1;
                        wslot = '{used: 1'b1, head: head_reg, tail: tail_reg,
                                  hash: hash_reg, age: '0};
                    end
                end
                CMD_SWEEP:
                begin
                    if (rslot.used)
                    begin
                        we = 1'b1;
                        if (!too_old)
                        begin
                            wslot     = rslot;
                            wslot.age = rslot.age + AGE_W'(1);
                        end
                    end
                end
                default: we = 1'b0;
            endcase
        end
    end

    cht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (SLOT_W'(wslot)),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            max_age_reg    <= MAX_AGE_RESET;
            idx_reg        <= '0;
            n_reg          <= '0;
            step_reg       <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            res_found_reg  <= 1'b0;
            res_status_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_age_reg <= cfg_data;
            // result register is reloaded in ST_RESP instead
            if (m_tready && state_reg != ST_RESP)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_inc;
                    if (idx_reg == LAST_IDX)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg        <= s_tuser[1:0];
                        sel_reg        <= s_tuser[3:2];
                        hash_reg       <= s_tdata[21:0];
                        head_reg       <= name_canon[HEAD_W+TAIL_W-1:TAIL_W];
                        tail_reg       <= name_canon[TAIL_W-1:0];
                        prod_reg       <= PROD_W'(h10 * HOME_MULT);
                        rem_reg        <= '0;
                        step_reg       <= '0;
                        n_reg          <= '0;
                        idx_reg        <= '0;
                        res_found_reg  <= 1'b0;
                        res_status_reg <= 1'b0;
                        res_head_reg   <= '0;
                        res_tail_reg   <= '0;
                        case (s_tuser[1:0])
                            CMD_SWEEP: state_reg <= ST_READ;
                            CMD_NOP:   state_reg <= ST_RESP;
                            default:   state_reg <= ST_HOME;
                        endcase
                    end
                end
                ST_HOME:
                begin
                    rem_reg  <= rem_next;
                    prod_reg <= prod_reg << STEP_BITS;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'(HOME_STEPS - 1))
                    begin
                        idx_reg   <= rem_next[AW-1:0];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                    state_reg <= ST_EVAL;
                ST_EVAL:
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!rslot.used)
                            begin
                                count_reg <= count_reg + CW'(1);
                                state_reg <= ST_RESP;
                            end
                            else if (add_match)
                            begin
                                res_found_reg <= 1'b1;
                                res_head_reg  <= rslot.head;
                                res_tail_reg  <= rslot.tail;
                                state_reg     <= ST_RESP;
                            end
                            else if (n_reg == LAST_IDX)
                            begin
                                res_status_reg <= 1'b1;
                                state_reg      <= ST_RESP;
                            end
                            else
                            begin
                                idx_reg <= idx_inc;
                                n_reg   <= n_reg + AW'(1);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (rslot.used && find_match)
                            begin
                                res_found_reg <= 1'b1;
                                res_head_reg  <= rslot.head;
                                res_tail_reg  <= rslot.tail;
                                state_reg     <= ST_RESP;
                            end
                            else
                            begin
                                if (!rslot.used || n_reg == LAST_IDX)
                                    state_reg <= ST_RESP;
                                idx_reg <= idx_inc;
                                n_reg   <= n_reg + AW'(1);
                            end
                        end
                        default:
                        begin
                            // age sweep, one slot per cycle
                            if (rslot.used && too_old)
                                count_reg <= count_reg - CW'(1);
                            idx_reg <= idx_inc;
                            if (idx_reg == LAST_IDX)
                                state_reg <= ST_RESP;
                        end
                    endcase
                end
                ST_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, OCC_W'(count_reg), res_tail_reg,
                                         res_head_reg};
                        m_tuser_reg  <= {res_status_reg, res_found_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // occupancy never exceeds the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("occupancy above table depth");

    // a dropped add never reports a hit
    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("full status together with found");

    // one item at a time: a transfer closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // nothing written outside the clearing pass and evaluation
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == ST_CLEAR || state_reg == ST_EVAL))
        else $error("slot write outside clear or evaluate");
`endif

endmodule

/* tb/callsign_hash_table_aging_tb.sv */
// ----------------------------------------------------------------------------
// callsign_hash_table_aging_tb
// Self-checking bench: a behavioural copy of the callsign table predicts each
// result, directed tests cover the corner cases, then random traffic runs with
// bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module callsign_hash_table_aging_tb;
    import cht_pkg::*;

    localparam int DEPTH     = 256;
    localparam int CYC_LIMIT = 1500000;

    typedef struct packed {
        logic              found;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
        logic              status;
        logic [OCC_W-1:0]  occ;
    } table_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    // Predictor state
    logic              mdl_used [DEPTH];
    logic [HEAD_W-1:0] mdl_head [DEPTH];
    logic [TAIL_W-1:0] mdl_tail [DEPTH];
    logic [HASH_W-1:0] mdl_hash [DEPTH];
    logic [AGE_W-1:0]  mdl_age  [DEPTH];
    int                mdl_total;
    logic [AGE_W-1:0]  mdl_max_age;

    table_result_t pending_results[$];
    // recently added keys, reused for refresh and lookup hits
    logic [HASH_W-1:0]        known_hash[$];
    logic [HEAD_W+TAIL_W-1:0] known_name[$];

    int  errors;
    int  cycles;
    bit  long_hold;      // receiver holds off while set
    bit  no_stall;

    callsign_hash_table_aging i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYC_LIMIT)
            begin
                $display("callsign_hash_table_aging_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [HEAD_W+TAIL_W-1:0] trim_name(logic [HEAD_W+TAIL_W-1:0] nm);
        logic [HEAD_W+TAIL_W-1:0] r;
        bit stop;
        r    = nm;
        stop = 0;
        for (int b = 10; b >= 0; b--)
        begin
            if (stop)
                r[b*8 +: 8] = '0;
            else if (nm[b*8 +: 8] == 8'h00)
                stop = 1;
        end
        return r;
    endfunction

    function automatic int start_slot(logic [HASH_W-1:0] h10);
        return ((int'(h10) & 'h3FF) * 23) % DEPTH;
    endfunction

    function automatic table_result_t predict_item(cmd_t cmd, sel_t sel,
        logic [HASH_W-1:0] hv, logic [HEAD_W+TAIL_W-1:0] nm_raw);
        table_result_t r;
        logic [HEAD_W+TAIL_W-1:0] nm;
        int  idx;
        int  sh;
        bit  done;
        r    = '0;
        nm   = trim_name(nm_raw);
        done = 0;
        case (cmd)
            CMD_ADD:
            begin
                idx = start_slot(hv >> 12);
                for (int n = 0; n < DEPTH && !done; n++)
                begin
                    if (!mdl_used[idx])
                    begin
                        mdl_used[idx] = 1'b1;
                        {mdl_head[idx], mdl_tail[idx]} = nm;
                        mdl_hash[idx] = hv;
                        mdl_age[idx]  = '0;
                        mdl_total++;
                        done = 1;
                    end
                    else if (mdl_hash[idx] == hv && {mdl_head[idx], mdl_tail[idx]} == nm)
                    begin
                        mdl_age[idx] = '0;
                        r.found = 1'b1;
                        r.head  = mdl_head[idx];
                        r.tail  = mdl_tail[idx];
                        done = 1;
                    end
                    else
                        idx = (idx + 1) % DEPTH;
                end
                if (!done)
                    r.status = 1'b1;
            end
            CMD_FIND:
            begin
                sh  = (sel == SEL_10) ? 12 : (sel == SEL_12) ? 10 : 0;
                idx = start_slot(hv >> (12 - sh));
                for (int n = 0; n < DEPTH && !done; n++)
                begin
                    if (!mdl_used[idx])
                        done = 1;
                    else if ((mdl_hash[idx] >> sh) == hv)
                    begin
                        r.found = 1'b1;
                        r.head  = mdl_head[idx];
                        r.tail  = mdl_tail[idx];
                        done = 1;
                    end
                    else
                        idx = (idx + 1) % DEPTH;
                end
            end
            CMD_SWEEP:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (mdl_used[i])
                    begin
                        if (mdl_age[i] > mdl_max_age)
                        begin
                            mdl_used[i] = 1'b0;
                            mdl_head[i] = '0;
                            mdl_tail[i] = '0;
                            mdl_hash[i] = '0;
                            mdl_age[i]  = '0;
                            mdl_total--;
                        end
                        else
                            mdl_age[i] = mdl_age[i] + 8'd1;
                    end
                end
            end
            default: ;
        endcase
        r.occ = OCC_W'(mdl_total);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    int burst_left;

    // One transfer on the input stream; random gaps between bursts.
    task automatic send_item(cmd_t cmd, sel_t sel, logic [HASH_W-1:0] hv,
        logic [HEAD_W+TAIL_W-1:0] nm);
        int gap;
        // valid drops after each transfer, before the next item is driven
        @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, nm[23:0], nm[87:24], hv};
        s_tuser  <= {sel, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_item(cmd, sel, hv, nm));
        if (cmd == CMD_ADD)
        begin
            known_hash.push_back(hv);
            known_name.push_back(nm);
            if (known_hash.size() > 64)
            begin
                void'(known_hash.pop_front());
                void'(known_name.pop_front());
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_max_age(logic [7:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        mdl_max_age = v;
    endtask

    function automatic logic [HEAD_W+TAIL_W-1:0] rand_name();
        logic [HEAD_W+TAIL_W-1:0] nm;
        for (int b = 0; b < 11; b++)
            nm[b*8 +: 8] = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
        return nm;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            table_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tuser[0] !== exp_r.found)
                begin
                    $error("found: expected %0h actual %0h", exp_r.found, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== exp_r.status)
                begin
                    $error("status: expected %0h actual %0h", exp_r.status, m_tuser[1]);
                    errors++;
                end
                if (m_tdata[63:0] !== exp_r.head)
                begin
                    $error("found_head: expected %0h actual %0h", exp_r.head, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[87:64] !== exp_r.tail)
                begin
                    $error("found_tail: expected %0h actual %0h", exp_r.tail, m_tdata[87:64]);
                    errors++;
                end
                if (m_tdata[96:88] !== exp_r.occ)
                begin
                    $error("occupied_count: expected %0d actual %0d", exp_r.occ,
                           m_tdata[96:88]);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern; a long hold-off when requested.
    initial
    begin
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
                long_hold = 0;
            end
            else if (no_stall)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        logic [HEAD_W+TAIL_W-1:0] nm;
        nm = {"AB1CDE", 8'h00, "XYZ", 8'h41};   // trailing bytes after zero
        send_item(CMD_FIND, SEL_22, 22'h0, '0);             // empty table
        send_item(CMD_ADD, SEL_10, 22'h3FFFFF, '1);
        send_item(CMD_ADD, SEL_10, 22'h000000, '0);         // empty name
        send_item(CMD_ADD, SEL_22, 22'h123456, nm);
        send_item(CMD_ADD, SEL_22, 22'h123456, {"AB1CDE", 40'h0}); // refresh
        send_item(CMD_ADD, SEL_12, 22'h123457, nm);         // same home slot
        send_item(CMD_FIND, SEL_10, 22'h123, '0);
        send_item(CMD_FIND, SEL_12, 22'h48D, '0);
        send_item(CMD_FIND, SEL_22, 22'h123457, '0);
        send_item(CMD_FIND, SEL_22B, 22'h3FFFFF, '0);
        send_item(CMD_FIND, SEL_10, 22'h3FFFFF, '0);        // too wide
        send_item(CMD_FIND, SEL_12, 22'h0FFF, '0);
        send_item(CMD_NOP, SEL_22B, 22'h3FFFFF, '1);
        send_item(CMD_SWEEP, SEL_10, 22'h0, '0);
    endtask

    task automatic test_max_age_extremes();
        write_max_age(8'd0);
        send_item(CMD_ADD, SEL_10, 22'h2AAAAA, {"G0ABC", 48'h0});
        send_item(CMD_SWEEP, SEL_10, 22'h0, '0);            // age 0 -> 1
        send_item(CMD_SWEEP, SEL_10, 22'h0, '0);            // removed
        write_max_age(8'd255);
        send_item(CMD_ADD, SEL_10, 22'h155555, {"K1XYZ", 48'h0});
        for (int i = 0; i < 4; i++)                         // kept at top limit
            send_item(CMD_SWEEP, SEL_10, 22'h0, '0);
        send_item(CMD_FIND, SEL_22, 22'h155555, '0);
    endtask

    // Fill every slot, then overflow adds and full-table lookups.
    task automatic test_full_table();
        write_max_age(8'd255);
        for (int i = 0; i < DEPTH + 4; i++)
            send_item(CMD_ADD, SEL_10, 22'($urandom_range(0, 'h3FFFFF)), rand_name());
        send_item(CMD_FIND, SEL_22, 22'h3FFFFF, '0);
        send_item(CMD_FIND, SEL_10, 22'h3FF, '0);
        write_max_age(8'd0);
        send_item(CMD_SWEEP, SEL_10, 22'h0, '0);
        send_item(CMD_SWEEP, SEL_10, 22'h0, '0);            // empties table
    endtask

    task automatic test_backpressure();
        long_hold = 1;
        for (int i = 0; i < 12; i++)
            send_item(CMD_ADD, SEL_10, 22'($urandom), rand_name());
        wait_idle();
    endtask

    task automatic test_random(int count);
        int k;
        cmd_t c;
        logic [HASH_W-1:0] hv;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 75)
            begin
                write_max_age(8'($urandom_range(1, 20)));
                no_stall = ($urandom_range(0, 1) == 0);
            end
            k = $urandom_range(0, 99);
            if (k < 40)
            begin
                if (known_hash.size() != 0 && $urandom_range(0, 2) == 0)
                begin
                    k = $urandom_range(0, known_hash.size() - 1);
                    send_item(CMD_ADD, sel_t'($urandom_range(0, 3)), known_hash[k],
                              known_name[k]);
                end
                else
                    send_item(CMD_ADD, sel_t'($urandom_range(0, 3)), 22'($urandom),
                              rand_name());
            end
            else if (k < 85)
            begin
                c  = CMD_FIND;
                hv = (known_hash.size() != 0)
                   ? known_hash[$urandom_range(0, known_hash.size() - 1)]
                   : 22'($urandom);
                case ($urandom_range(0, 4))
                    0: send_item(c, SEL_10, hv >> 12, rand_name());
                    1: send_item(c, SEL_12, hv >> 10, rand_name());
                    2: send_item(c, SEL_22, hv, rand_name());
                    3: send_item(c, SEL_22B, hv, rand_name());
                    default: send_item(c, sel_t'($urandom_range(0, 3)), 22'($urandom),
                                       rand_name());
                endcase
            end
            else if (k < 93)
                send_item(CMD_SWEEP, sel_t'($urandom_range(0, 3)), 22'($urandom),
                          rand_name());
            else
                send_item(CMD_NOP, sel_t'($urandom_range(0, 3)), 22'($urandom),
                          rand_name());
        end
    endtask

    initial
    begin
        errors      = 0;
        burst_left  = 0;
        long_hold   = 0;
        no_stall    = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        mdl_max_age = MAX_AGE_RESET;
        mdl_total   = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            mdl_used[i] = 1'b0;
            mdl_head[i] = '0;
            mdl_tail[i] = '0;
            mdl_hash[i] = '0;
            mdl_age[i]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_max_age_extremes();
        test_full_table();
        write_max_age(8'd10);
        test_backpressure();
        test_random(150);

        wait_idle();
        if (errors == 0)
            $display("callsign_hash_table_aging_tb OK");
        else
            $display("callsign_hash_table_aging_tb NOT OK");
        $finish;
    end

endmodule
